[hw/rtl/bounded_bag_table_top_defines.svh]
// Assertion macros shared by the RTL. Each samples on clk and is off during reset.
`ifndef BOUNDED_BAG_TABLE_TOP_DEFINES_SVH
`define BOUNDED_BAG_TABLE_TOP_DEFINES_SVH

// Same-cycle implication.
`define BBT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bounded_bag_table assertion failed");

// Next-cycle implication.
`define BBT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bounded_bag_table assertion failed");

`endif

[hw/rtl/bbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bbt_pkg;

	localparam int REQ_W   = 3;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 5;
	localparam int CAP_W   = 5;

	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_TEST   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_FIRST  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_NEXT   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

	localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
	localparam logic [VALUE_W-1:0] DATA_FAIL = '1;

	// Result word handed from the core to the top level.
	typedef struct packed {
		logic                      done;
		logic [STAT_W-1:0]         status;
		logic signed [VALUE_W-1:0] data;
		logic [CNT_W-1:0]          count;
	} res_t;

endpackage

`default_nettype wire

[hw/rtl/bbt_core.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_bag_table_top_defines.svh"

module bbt_core #(
	parameter int DEPTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [bbt_pkg::REQ_W-1:0]         req_type,
	input  wire logic signed [bbt_pkg::VALUE_W-1:0] value,
	input  wire logic [$clog2(DEPTH+1)-1:0]        limit,
	output logic                                   busy,
	output bbt_pkg::res_t                          res
);

	localparam int FW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FETCH,
		ST_LOAD
	} state_t;

	state_t                          state_q;
	logic [bbt_pkg::REQ_W-1:0]       req_q;
	logic [bbt_pkg::VALUE_W-1:0]     key_q;
	logic [FW-1:0]                   fill_q;
	logic [FW-1:0]                   cursor_q;
	logic [FW-1:0]                   idx_q;
	logic                            cmp_v_s1;
	logic [FW-1:0]                   cmp_idx_s1;
	logic                            wr_v_s1;
	logic [AW-1:0]                   wr_idx_s1;
	logic                            done_q;
	logic [bbt_pkg::STAT_W-1:0]      status_q;
	logic [bbt_pkg::VALUE_W-1:0]     data_q;

	logic [bbt_pkg::VALUE_W-1:0]     mem [DEPTH];
	logic [bbt_pkg::VALUE_W-1:0]     rd_data_q;
	logic                            mem_we;
	logic [AW-1:0]                   mem_wa;
	logic [bbt_pkg::VALUE_W-1:0]     mem_wd;
	logic [AW-1:0]                   mem_ra;

	logic                            match;
	logic [FW-1:0]                   idx_inc;
	logic [FW-1:0]                   idx_dec;
	logic [FW-1:0]                   cmp_inc;

	assign idx_inc = idx_q + 1'b1;
	assign idx_dec = idx_q - 1'b1;
	assign cmp_inc = cmp_idx_s1 + 1'b1;

	// Shared comparator: key against the word read in the cycle before.
	assign match = cmp_v_s1 && (rd_data_q == key_q);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = fill_q[AW-1:0];
		mem_wd = value;
		mem_ra = idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (start && (req_type == bbt_pkg::REQ_INSERT) && (fill_q < limit)) begin
					mem_we = 1'b1;
				end
			end
			ST_SHIFT: begin
				mem_we = wr_v_s1;
				mem_wa = wr_idx_s1;
				mem_wd = rd_data_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			req_q      <= bbt_pkg::REQ_INSERT;
			key_q      <= '0;
			fill_q     <= '0;
			cursor_q   <= '0;
			idx_q      <= '0;
			cmp_v_s1   <= 1'b0;
			cmp_idx_s1 <= '0;
			wr_v_s1    <= 1'b0;
			wr_idx_s1  <= '0;
			done_q     <= 1'b0;
			status_q   <= bbt_pkg::ST_OK;
			data_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q    <= req_type;
						key_q    <= value;
						idx_q    <= '0;
						cmp_v_s1 <= 1'b0;
						status_q <= bbt_pkg::ST_OK;
						data_q   <= '0;
						case (req_type)
							bbt_pkg::REQ_INSERT: begin
								done_q <= 1'b1;
								if (fill_q < limit) begin
									fill_q <= fill_q + 1'b1;
								end else begin
									status_q <= bbt_pkg::ST_FULL;
								end
							end
							bbt_pkg::REQ_REMOVE, bbt_pkg::REQ_TEST: begin
								state_q <= ST_SCAN;
							end
							bbt_pkg::REQ_FIRST: begin
								if (fill_q != '0) begin
									state_q <= ST_FETCH;
								end else begin
									done_q   <= 1'b1;
									status_q <= bbt_pkg::ST_EMPTY;
								end
							end
							bbt_pkg::REQ_NEXT: begin
								if (cursor_q < fill_q) begin
									idx_q   <= cursor_q;
									state_q <= ST_FETCH;
								end else begin
									done_q   <= 1'b1;
									status_q <= bbt_pkg::ST_EMPTY;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					cmp_v_s1 <= 1'b0;
					if (match) begin
						if (req_q == bbt_pkg::REQ_REMOVE) begin
							// hold the removed word, then close the gap above it
							data_q  <= rd_data_q;
							idx_q   <= cmp_inc;
							wr_v_s1 <= 1'b0;
							state_q <= ST_SHIFT;
						end else begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else if (idx_q >= fill_q) begin
						done_q   <= 1'b1;
						status_q <= bbt_pkg::ST_NOTFOUND;
						data_q   <= (req_q == bbt_pkg::REQ_REMOVE) ? bbt_pkg::DATA_FAIL : '0;
						state_q  <= ST_IDLE;
					end else begin
						idx_q      <= idx_inc;
						cmp_v_s1   <= 1'b1;
						cmp_idx_s1 <= idx_q;
					end
				end
				ST_SHIFT: begin
					wr_v_s1 <= 1'b0;
					if (idx_q < fill_q) begin
						idx_q     <= idx_inc;
						wr_v_s1   <= 1'b1;
						wr_idx_s1 <= idx_dec[AW-1:0];
					end else if (!wr_v_s1) begin
						done_q  <= 1'b1;
						fill_q  <= fill_q - 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_FETCH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					done_q <= 1'b1;
					data_q <= rd_data_q;
					if (req_q == bbt_pkg::REQ_NEXT) begin
						cursor_q <= cursor_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign res.done   = done_q;
	assign res.status = status_q;
	assign res.data   = data_q;
	assign res.count  = bbt_pkg::CNT_W'(fill_q);

	`BBT_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FW'(DEPTH))
	`BBT_ASSERT_IMP(a_write_below_fill, mem_we && (state_q == ST_SHIFT), {1'b0, wr_idx_s1} < fill_q)
	`BBT_ASSERT_NXT(a_busy_ends_done, state_q != ST_IDLE, (state_q != ST_IDLE) || done_q)
	`BBT_ASSERT_IMP(a_fill_step, 1'b1, (fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + 1'b1) || (fill_q + 1'b1 == $past(fill_q)))

endmodule

`default_nettype wire

[hw/rtl/bounded_bag_table_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Bounded bag of signed 32-bit words, kept compact in a DEPTH-entry table.
// Command channel: a request (req_type, value) is taken at a rising edge with
// start high and busy low; busy stays high until that request has finished.
// Result channel: done pulses for one cycle with status, data and count; the
// receiver cannot stall, so it must take the word in that cycle.
// Config: cfg_we writes cfg_wdata into the capacity register at any edge;
// write it only while the block is idle. The insert limit is min(capacity, DEPTH).
// Request flow:
//   insert, empty/unused requests: done in the cycle after the accept, block ready
//   again at once;
//   get first / next by cursor: FETCH then LOAD states (memory read is registered);
//   membership test: one table word through the comparator per cycle;
//   remove: scan to the match, then one shifted word per cycle; the single-port
//   table read sets the pace.
// Reset (arst_n low) empties the bag, clears the cursor and sets capacity to 16;
// table contents are not cleared and need no clearing pass.
module bounded_bag_table_top #(
	parameter int DEPTH = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [bbt_pkg::REQ_W-1:0]          req_type,
	input  wire logic signed [bbt_pkg::VALUE_W-1:0] value,
	input  wire logic                               cfg_we,
	input  wire logic [bbt_pkg::CAP_W-1:0]          cfg_wdata,
	output logic                                    done,
	output logic [bbt_pkg::STAT_W-1:0]              status,
	output logic signed [bbt_pkg::VALUE_W-1:0]      data,
	output logic [bbt_pkg::CNT_W-1:0]               count
);

	localparam int FW = $clog2(DEPTH + 1);
	// common width for comparing capacity against DEPTH
	localparam int LW = (FW > bbt_pkg::CAP_W) ? FW : bbt_pkg::CAP_W;

	logic [bbt_pkg::CAP_W-1:0] cap_q;
	logic [LW-1:0]             cap_ext;
	logic [FW-1:0]             limit;
	bbt_pkg::res_t             res;

	// Hold the capacity register; written whenever cfg_we is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bbt_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Saturate the insert limit at the table depth.
	assign cap_ext = LW'(cap_q);
	assign limit   = (cap_ext >= LW'(DEPTH)) ? FW'(DEPTH) : FW'(cap_ext);

	bbt_core #(
		.DEPTH (DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.value    (value),
		.limit    (limit),
		.busy     (busy),
		.res      (res)
	);

	// Drive the result word onto its ports.
	assign done   = res.done;
	assign status = res.status;
	assign data   = res.data;
	assign count  = res.count;

endmodule

`default_nettype wire
